[sv/c6502eu_pkg.sv]
package c6502eu_pkg;

    // Operation codes carried in the kind field
    localparam logic [5:0] K_ADC     = 6'd0;
    localparam logic [5:0] K_SBC     = 6'd1;
    localparam logic [5:0] K_AND     = 6'd2;
    localparam logic [5:0] K_EOR     = 6'd3;
    localparam logic [5:0] K_ORA     = 6'd4;
    localparam logic [5:0] K_BIT     = 6'd5;
    localparam logic [5:0] K_CMP     = 6'd6;
    localparam logic [5:0] K_CPX     = 6'd7;
    localparam logic [5:0] K_CPY     = 6'd8;
    localparam logic [5:0] K_LDA     = 6'd9;
    localparam logic [5:0] K_LDX     = 6'd10;
    localparam logic [5:0] K_LDY     = 6'd11;
    localparam logic [5:0] K_INC     = 6'd12;
    localparam logic [5:0] K_INX     = 6'd13;
    localparam logic [5:0] K_INY     = 6'd14;
    localparam logic [5:0] K_DEC     = 6'd15;
    localparam logic [5:0] K_DEX     = 6'd16;
    localparam logic [5:0] K_DEY     = 6'd17;
    localparam logic [5:0] K_ASL_A   = 6'd18;
    localparam logic [5:0] K_ASL_M   = 6'd19;
    localparam logic [5:0] K_LSR_A   = 6'd20;
    localparam logic [5:0] K_LSR_M   = 6'd21;
    localparam logic [5:0] K_ROL_A   = 6'd22;
    localparam logic [5:0] K_ROL_M   = 6'd23;
    localparam logic [5:0] K_ROR_A   = 6'd24;
    localparam logic [5:0] K_ROR_M   = 6'd25;
    localparam logic [5:0] K_BCC     = 6'd26;
    localparam logic [5:0] K_BCS     = 6'd27;
    localparam logic [5:0] K_BEQ     = 6'd28;
    localparam logic [5:0] K_BMI     = 6'd29;
    localparam logic [5:0] K_BNE     = 6'd30;
    localparam logic [5:0] K_BPL     = 6'd31;
    localparam logic [5:0] K_BVC     = 6'd32;
    localparam logic [5:0] K_BVS     = 6'd33;
    localparam logic [5:0] K_JMP     = 6'd34;
    localparam logic [5:0] K_TAX     = 6'd35;
    localparam logic [5:0] K_TAY     = 6'd36;
    localparam logic [5:0] K_TXA     = 6'd37;
    localparam logic [5:0] K_TYA     = 6'd38;
    localparam logic [5:0] K_TSX     = 6'd39;
    localparam logic [5:0] K_TXS     = 6'd40;

    // Status bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    typedef struct packed {
        logic [5:0]        kind;
        logic [7:0]        value;
        logic [15:0]       addr;
        logic [1:0]        len;
        logic signed [7:0] offset;
    } t_item;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  p;
        logic [15:0] pc;
    } t_regs;

    typedef struct packed {
        logic        valid;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_wr;

endpackage

[sv/cpu6502_execute_unit_top.sv]
// Channel   Handshake                     Word
// input     i_in_valid / o_in_ready       i_kind, i_operand_value, i_operand_address,
//                                         i_operand_length, i_branch_offset
// output    o_out_valid / i_out_ready     o_mem_write_*, o_accumulator, o_index_x,
//                                         o_index_y, o_stack_pointer, o_status_flags,
//                                         o_program_counter
//
// One instruction a cycle while the result is taken: an input register feeds the execute logic, whose result is
// written into the register file and the result register in the same cycle.
// An accepted word is held in the input register until the result register can take its result.
// Reset clears A, X, Y, SP, flags and PC to zero and empties both registers.
// While the result is not taken the input register still accepts one word, then holds.
module cpu6502_execute_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [5:0]  i_kind,
    input  logic [7:0]  i_operand_value,
    input  logic [15:0] i_operand_address,
    input  logic [1:0]  i_operand_length,
    input  logic signed [7:0] i_branch_offset,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_mem_write_valid,
    output logic [15:0] o_mem_write_address,
    output logic [7:0]  o_mem_write_data,
    output logic [7:0]  o_accumulator,
    output logic [7:0]  o_index_x,
    output logic [7:0]  o_index_y,
    output logic [7:0]  o_stack_pointer,
    output logic [7:0]  o_status_flags,
    output logic [15:0] o_program_counter
);

    c6502eu_pkg::t_item in_item;
    c6502eu_pkg::t_item ex_item;
    c6502eu_pkg::t_regs n_regs;
    c6502eu_pkg::t_wr   n_wr;
    c6502eu_pkg::t_regs r_regs;
    c6502eu_pkg::t_wr   r_wr;
    logic               r_out_valid;
    logic               ex_valid;
    logic               ex_fire;

    assign in_item.kind   = i_kind;
    assign in_item.value  = i_operand_value;
    assign in_item.addr   = i_operand_address;
    assign in_item.len    = i_operand_length;
    assign in_item.offset = i_branch_offset;

    // The register file only moves when a result word is produced, so the shown
    // registers always belong to the word in the result register.
    assign ex_fire = ex_valid && (!r_out_valid || i_out_ready);

    c6502eu_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (ex_valid),
        .o_item  (ex_item),
        .i_take  (ex_fire)
    );

    c6502eu_alu u_alu (
        .i_item (ex_item),
        .i_regs (r_regs),
        .o_regs (n_regs),
        .o_wr   (n_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs      <= '0;
            r_out_valid <= 1'b0;
        end else if (ex_fire) begin
            r_regs      <= n_regs;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
        end else if (ex_fire) begin
            r_wr <= n_wr;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_mem_write_valid   = r_wr.valid;
    assign o_mem_write_address = r_wr.addr;
    assign o_mem_write_data    = r_wr.data;
    assign o_accumulator       = r_regs.a;
    assign o_index_x           = r_regs.x;
    assign o_index_y           = r_regs.y;
    assign o_stack_pointer     = r_regs.sp;
    assign o_status_flags      = r_regs.p;
    assign o_program_counter   = r_regs.pc;

endmodule

[sv/c6502eu_in_reg.sv]
module c6502eu_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  c6502eu_pkg::t_item  i_item,
    output logic                o_valid,
    output c6502eu_pkg::t_item  o_item,
    input  logic                i_take
);

    logic               r_valid;
    c6502eu_pkg::t_item r_item;

    // A word may enter in the same cycle that the held one moves on.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[sv/c6502eu_alu.sv]
module c6502eu_alu (
    input  c6502eu_pkg::t_item i_item,
    input  c6502eu_pkg::t_regs i_regs,
    output c6502eu_pkg::t_regs o_regs,
    output c6502eu_pkg::t_wr   o_wr
);

    logic [15:0] pc_long;
    logic [15:0] pc_short;
    logic [15:0] pc_branch;
    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic        add_c;
    logic [8:0]  sum;
    logic        ovf;
    logic [7:0]  sh_src;
    logic [7:0]  sh_res;
    logic        sh_c;
    logic        take;
    logic [7:0]  m;
    logic [7:0]  p;

    function automatic logic [7:0] put_nz(input logic [7:0] flags, input logic [7:0] v);
        logic [7:0] f;
        f = flags;
        f[c6502eu_pkg::FLAG_N] = v[7];
        f[c6502eu_pkg::FLAG_Z] = (v == 8'd0);
        return f;
    endfunction

    assign m = i_item.value;
    assign p = i_regs.p;

    assign pc_long   = i_regs.pc + {14'd0, i_item.len} + 16'd1;
    assign pc_short  = i_regs.pc + 16'd1;
    assign pc_branch = pc_long + {{8{i_item.offset[7]}}, i_item.offset};

    // One adder serves ADC, SBC and the three compares.
    assign add_a = (i_item.kind == c6502eu_pkg::K_CPX) ? i_regs.x :
                   (i_item.kind == c6502eu_pkg::K_CPY) ? i_regs.y : i_regs.a;
    assign add_b = (i_item.kind == c6502eu_pkg::K_ADC) ? m : ~m;
    assign add_c = (i_item.kind == c6502eu_pkg::K_ADC || i_item.kind == c6502eu_pkg::K_SBC) ?
                   p[c6502eu_pkg::FLAG_C] : 1'b1;
    assign sum   = {1'b0, add_a} + {1'b0, add_b} + {8'd0, add_c};
    assign ovf   = ~(add_a[7] ^ add_b[7]) & (add_a[7] ^ sum[7]);

    // Odd codes in the shift group work on memory, even ones on A.
    assign sh_src = i_item.kind[0] ? m : i_regs.a;

    always_comb begin
        sh_res = sh_src;
        sh_c   = p[c6502eu_pkg::FLAG_C];
        unique case (i_item.kind)
            c6502eu_pkg::K_ASL_A, c6502eu_pkg::K_ASL_M: begin
                sh_res = {sh_src[6:0], 1'b0};
                sh_c   = sh_src[7];
            end
            c6502eu_pkg::K_LSR_A, c6502eu_pkg::K_LSR_M: begin
                sh_res = {1'b0, sh_src[7:1]};
                sh_c   = sh_src[0];
            end
            c6502eu_pkg::K_ROL_A, c6502eu_pkg::K_ROL_M: begin
                sh_res = {sh_src[6:0], p[c6502eu_pkg::FLAG_C]};
                sh_c   = sh_src[7];
            end
            c6502eu_pkg::K_ROR_A, c6502eu_pkg::K_ROR_M: begin
                sh_res = {p[c6502eu_pkg::FLAG_C], sh_src[7:1]};
                sh_c   = sh_src[0];
            end
            default: begin
                sh_res = sh_src;
                sh_c   = p[c6502eu_pkg::FLAG_C];
            end
        endcase
    end

    always_comb begin
        unique case (i_item.kind)
            c6502eu_pkg::K_BCC: take = !p[c6502eu_pkg::FLAG_C];
            c6502eu_pkg::K_BCS: take =  p[c6502eu_pkg::FLAG_C];
            c6502eu_pkg::K_BEQ: take =  p[c6502eu_pkg::FLAG_Z];
            c6502eu_pkg::K_BMI: take =  p[c6502eu_pkg::FLAG_N];
            c6502eu_pkg::K_BNE: take = !p[c6502eu_pkg::FLAG_Z];
            c6502eu_pkg::K_BPL: take = !p[c6502eu_pkg::FLAG_N];
            c6502eu_pkg::K_BVC: take = !p[c6502eu_pkg::FLAG_V];
            c6502eu_pkg::K_BVS: take =  p[c6502eu_pkg::FLAG_V];
            default:            take = 1'b0;
        endcase
    end

    always_comb begin
        o_regs = i_regs;
        o_wr   = '0;
        unique case (i_item.kind)
            c6502eu_pkg::K_ADC, c6502eu_pkg::K_SBC: begin
                o_regs.a = sum[7:0];
                o_regs.p = put_nz(p, sum[7:0]);
                o_regs.p[c6502eu_pkg::FLAG_C] = sum[8];
                o_regs.p[c6502eu_pkg::FLAG_V] = ovf;
                o_regs.pc = pc_long;
            end
            c6502eu_pkg::K_AND: begin
                o_regs.a  = i_regs.a & m;
                o_regs.p  = put_nz(p, i_regs.a & m);
                o_regs.pc = pc_long;
            end
            c6502eu_pkg::K_EOR: begin
                o_regs.a  = i_regs.a ^ m;
                o_regs.p  = put_nz(p, i_regs.a ^ m);
                o_regs.pc = pc_long;
            end
            c6502eu_pkg::K_ORA: begin
                o_regs.a  = i_regs.a | m;
                o_regs.p  = put_nz(p, i_regs.a | m);
                o_regs.pc = pc_long;
            end
            c6502eu_pkg::K_BIT: begin
                o_regs.p[c6502eu_pkg::FLAG_N] = m[7];
                o_regs.p[c6502eu_pkg::FLAG_V] = m[6];
                o_regs.p[c6502eu_pkg::FLAG_Z] = ((i_regs.a & m) == 8'd0);
                o_regs.pc = pc_long;
            end
            c6502eu_pkg::K_CMP, c6502eu_pkg::K_CPX, c6502eu_pkg::K_CPY: begin
                o_regs.p = put_nz(p, sum[7:0]);
                o_regs.p[c6502eu_pkg::FLAG_C] = sum[8];
                o_regs.pc = pc_long;
            end
            c6502eu_pkg::K_LDA: begin
                o_regs.a  = m;
                o_regs.p  = put_nz(p, m);
                o_regs.pc = pc_long;
            end
            c6502eu_pkg::K_LDX: begin
                o_regs.x  = m;
                o_regs.p  = put_nz(p, m);
                o_regs.pc = pc_long;
            end
            c6502eu_pkg::K_LDY: begin
                o_regs.y  = m;
                o_regs.p  = put_nz(p, m);
                o_regs.pc = pc_long;
            end
            c6502eu_pkg::K_INC: begin
                o_wr.valid = 1'b1;
                o_wr.addr  = i_item.addr;
                o_wr.data  = m + 8'd1;
                o_regs.p   = put_nz(p, m + 8'd1);
                o_regs.pc  = pc_long;
            end
            c6502eu_pkg::K_DEC: begin
                o_wr.valid = 1'b1;
                o_wr.addr  = i_item.addr;
                o_wr.data  = m - 8'd1;
                o_regs.p   = put_nz(p, m - 8'd1);
                o_regs.pc  = pc_long;
            end
            c6502eu_pkg::K_INX: begin
                o_regs.x  = i_regs.x + 8'd1;
                o_regs.p  = put_nz(p, i_regs.x + 8'd1);
                o_regs.pc = pc_short;
            end
            c6502eu_pkg::K_INY: begin
                o_regs.y  = i_regs.y + 8'd1;
                o_regs.p  = put_nz(p, i_regs.y + 8'd1);
                o_regs.pc = pc_short;
            end
            c6502eu_pkg::K_DEX: begin
                o_regs.x  = i_regs.x - 8'd1;
                o_regs.p  = put_nz(p, i_regs.x - 8'd1);
                o_regs.pc = pc_short;
            end
            c6502eu_pkg::K_DEY: begin
                o_regs.y  = i_regs.y - 8'd1;
                o_regs.p  = put_nz(p, i_regs.y - 8'd1);
                o_regs.pc = pc_short;
            end
            c6502eu_pkg::K_ASL_A, c6502eu_pkg::K_LSR_A,
            c6502eu_pkg::K_ROL_A, c6502eu_pkg::K_ROR_A: begin
                o_regs.a = sh_res;
                o_regs.p = put_nz(p, sh_res);
                o_regs.p[c6502eu_pkg::FLAG_C] = sh_c;
                o_regs.pc = pc_short;
            end
            c6502eu_pkg::K_ASL_M, c6502eu_pkg::K_LSR_M,
            c6502eu_pkg::K_ROL_M, c6502eu_pkg::K_ROR_M: begin
                o_wr.valid = 1'b1;
                o_wr.addr  = i_item.addr;
                o_wr.data  = sh_res;
                o_regs.p   = put_nz(p, sh_res);
                o_regs.p[c6502eu_pkg::FLAG_C] = sh_c;
                o_regs.pc = pc_long;
            end
            c6502eu_pkg::K_BCC, c6502eu_pkg::K_BCS, c6502eu_pkg::K_BEQ, c6502eu_pkg::K_BMI,
            c6502eu_pkg::K_BNE, c6502eu_pkg::K_BPL, c6502eu_pkg::K_BVC, c6502eu_pkg::K_BVS: begin
                o_regs.pc = take ? pc_branch : pc_long;
            end
            c6502eu_pkg::K_JMP: begin
                o_regs.pc = i_item.addr;
            end
            c6502eu_pkg::K_TAX: begin
                o_regs.x  = i_regs.a;
                o_regs.p  = put_nz(p, i_regs.a);
                o_regs.pc = pc_short;
            end
            c6502eu_pkg::K_TAY: begin
                o_regs.y  = i_regs.a;
                o_regs.p  = put_nz(p, i_regs.a);
                o_regs.pc = pc_short;
            end
            c6502eu_pkg::K_TXA: begin
                o_regs.a  = i_regs.x;
                o_regs.p  = put_nz(p, i_regs.x);
                o_regs.pc = pc_short;
            end
            c6502eu_pkg::K_TYA: begin
                o_regs.a  = i_regs.y;
                o_regs.p  = put_nz(p, i_regs.y);
                o_regs.pc = pc_short;
            end
            c6502eu_pkg::K_TSX: begin
                o_regs.x  = i_regs.sp;
                o_regs.p  = put_nz(p, i_regs.sp);
                o_regs.pc = pc_short;
            end
            c6502eu_pkg::K_TXS: begin
                o_regs.sp = i_regs.x;
                o_regs.pc = pc_short;
            end
            default: begin
                // Codes without a meaning leave everything as it was.
                o_regs = i_regs;
            end
        endcase
    end

endmodule

[sv/c6502eu_chk.sv]
module c6502eu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_mem_write_valid,
    input logic [15:0] o_mem_write_address,
    input logic [7:0]  o_mem_write_data,
    input logic [7:0]  o_status_flags
);

    // A result word waiting to be taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    // With the result register empty, the input side can never be blocked.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result register empty");

    // Without a memory write, its address and data read as zero.
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_mem_write_valid |->
            (o_mem_write_address == 16'd0) && (o_mem_write_data == 8'd0))
        else $error("memory write fields not zero without a write");

    // No instruction here touches bits 5 to 2 of the status, so they stay clear.
    a_flags_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status_flags[5:2] == 4'd0)
        else $error("status bits 5 to 2 changed");

    // After reset nothing is offered.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

bind cpu6502_execute_unit_top c6502eu_chk u_c6502eu_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_mem_write_valid   (o_mem_write_valid),
    .o_mem_write_address (o_mem_write_address),
    .o_mem_write_data    (o_mem_write_data),
    .o_status_flags      (o_status_flags)
);

[dv/cpu6502_execute_unit_top_tb.sv]
`timescale 1ns / 100ps

module cpu6502_execute_unit_top_tb;

    localparam logic [5:0] KIND_MAX   = 6'h3F;
    localparam int unsigned RAND_INSTR = 550;

    typedef struct packed {
        c6502eu_pkg::t_wr   wr;
        c6502eu_pkg::t_regs regs;
    } t_exec_result;

    typedef struct {
        c6502eu_pkg::t_item instr;
        int unsigned        gap;
        bit                 drain;
    } t_pending_instr;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    c6502eu_pkg::t_item cur_instr = '0;
    logic        in_ready;
    logic        out_valid;
    logic        mem_wr_valid;
    logic [15:0] mem_wr_addr;
    logic [7:0]  mem_wr_data;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  flags_out;
    logic [15:0] pc_out;

    // Architectural state as the execute stage should hold it.
    logic [7:0]  acc_r   = '0;
    logic [7:0]  x_r     = '0;
    logic [7:0]  y_r     = '0;
    logic [7:0]  sp_r    = '0;
    logic [7:0]  flags_r = '0;
    logic [15:0] pc_r    = '0;

    t_pending_instr instr_q[$];
    t_exec_result   expected_state_q[$];

    int unsigned idle_cnt     = 0;
    int unsigned stall_cnt    = 0;
    int unsigned n_sent       = 0;
    int unsigned n_checked    = 0;
    int unsigned n_taken      = 0;
    int unsigned n_mem_writes = 0;
    int unsigned n_errors     = 0;

    always #10 clk = ~clk;

    cpu6502_execute_unit_top u_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_kind              (cur_instr.kind),
        .i_operand_value     (cur_instr.value),
        .i_operand_address   (cur_instr.addr),
        .i_operand_length    (cur_instr.len),
        .i_branch_offset     (cur_instr.offset),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_mem_write_valid   (mem_wr_valid),
        .o_mem_write_address (mem_wr_addr),
        .o_mem_write_data    (mem_wr_data),
        .o_accumulator       (acc_out),
        .o_index_x           (x_out),
        .o_index_y           (y_out),
        .o_stack_pointer     (sp_out),
        .o_status_flags      (flags_out),
        .o_program_counter   (pc_out)
    );

    function automatic void set_nz(logic [7:0] v);
        flags_r[c6502eu_pkg::FLAG_N] = v[7];
        flags_r[c6502eu_pkg::FLAG_Z] = (v == 8'h00);
    endfunction

    function automatic logic [7:0] add_with_flags(logic [7:0] a, logic [7:0] b,
                                                  logic cin, logic set_v);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        flags_r[c6502eu_pkg::FLAG_C] = sum[8];
        if (set_v) begin
            flags_r[c6502eu_pkg::FLAG_V] = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
        end
        set_nz(sum[7:0]);
        return sum[7:0];
    endfunction

    function automatic t_exec_result execute_instr(c6502eu_pkg::t_item it);
        t_exec_result res;
        logic [7:0]   m;
        logic [7:0]   t;
        logic [7:0]   wdata;
        logic         carry;
        logic         take;
        logic         wr;
        m     = it.value;
        carry = flags_r[c6502eu_pkg::FLAG_C];
        t     = '0;
        wdata = '0;
        take  = 1'b0;
        wr    = 1'b0;

        // Anything with an operand but JMP steps over it; implied forms step by one.
        if (it.kind <= c6502eu_pkg::K_INC || it.kind == c6502eu_pkg::K_DEC ||
            it.kind == c6502eu_pkg::K_ASL_M || it.kind == c6502eu_pkg::K_LSR_M ||
            it.kind == c6502eu_pkg::K_ROL_M || it.kind == c6502eu_pkg::K_ROR_M ||
            (it.kind >= c6502eu_pkg::K_BCC && it.kind <= c6502eu_pkg::K_BVS)) begin
            pc_r = pc_r + {14'd0, it.len} + 16'd1;
        end else if (it.kind <= c6502eu_pkg::K_TXS && it.kind != c6502eu_pkg::K_JMP) begin
            pc_r = pc_r + 16'd1;
        end

        case (it.kind)
            c6502eu_pkg::K_ADC: acc_r = add_with_flags(acc_r, m, carry, 1'b1);
            c6502eu_pkg::K_SBC: acc_r = add_with_flags(acc_r, ~m, carry, 1'b1);
            c6502eu_pkg::K_AND: begin acc_r = acc_r & m; set_nz(acc_r); end
            c6502eu_pkg::K_EOR: begin acc_r = acc_r ^ m; set_nz(acc_r); end
            c6502eu_pkg::K_ORA: begin acc_r = acc_r | m; set_nz(acc_r); end
            c6502eu_pkg::K_BIT: begin
                flags_r[c6502eu_pkg::FLAG_N] = m[7];
                flags_r[c6502eu_pkg::FLAG_V] = m[6];
                flags_r[c6502eu_pkg::FLAG_Z] = ((acc_r & m) == 8'h00);
            end
            c6502eu_pkg::K_CMP: void'(add_with_flags(acc_r, ~m, 1'b1, 1'b0));
            c6502eu_pkg::K_CPX: void'(add_with_flags(x_r, ~m, 1'b1, 1'b0));
            c6502eu_pkg::K_CPY: void'(add_with_flags(y_r, ~m, 1'b1, 1'b0));
            c6502eu_pkg::K_LDA: begin acc_r = m; set_nz(m); end
            c6502eu_pkg::K_LDX: begin x_r = m; set_nz(m); end
            c6502eu_pkg::K_LDY: begin y_r = m; set_nz(m); end
            c6502eu_pkg::K_INC: begin wdata = m + 8'd1; wr = 1'b1; set_nz(wdata); end
            c6502eu_pkg::K_INX: begin x_r = x_r + 8'd1; set_nz(x_r); end
            c6502eu_pkg::K_INY: begin y_r = y_r + 8'd1; set_nz(y_r); end
            c6502eu_pkg::K_DEC: begin wdata = m - 8'd1; wr = 1'b1; set_nz(wdata); end
            c6502eu_pkg::K_DEX: begin x_r = x_r - 8'd1; set_nz(x_r); end
            c6502eu_pkg::K_DEY: begin y_r = y_r - 8'd1; set_nz(y_r); end
            c6502eu_pkg::K_ASL_A, c6502eu_pkg::K_ASL_M: begin
                t = (it.kind == c6502eu_pkg::K_ASL_A) ? acc_r : m;
                flags_r[c6502eu_pkg::FLAG_C] = t[7];
                t = {t[6:0], 1'b0};
            end
            c6502eu_pkg::K_LSR_A, c6502eu_pkg::K_LSR_M: begin
                t = (it.kind == c6502eu_pkg::K_LSR_A) ? acc_r : m;
                flags_r[c6502eu_pkg::FLAG_C] = t[0];
                t = {1'b0, t[7:1]};
            end
            c6502eu_pkg::K_ROL_A, c6502eu_pkg::K_ROL_M: begin
                t = (it.kind == c6502eu_pkg::K_ROL_A) ? acc_r : m;
                flags_r[c6502eu_pkg::FLAG_C] = t[7];
                t = {t[6:0], carry};
            end
            c6502eu_pkg::K_ROR_A, c6502eu_pkg::K_ROR_M: begin
                t = (it.kind == c6502eu_pkg::K_ROR_A) ? acc_r : m;
                flags_r[c6502eu_pkg::FLAG_C] = t[0];
                t = {carry, t[7:1]};
            end
            c6502eu_pkg::K_BCC: take = !flags_r[c6502eu_pkg::FLAG_C];
            c6502eu_pkg::K_BCS: take = flags_r[c6502eu_pkg::FLAG_C];
            c6502eu_pkg::K_BEQ: take = flags_r[c6502eu_pkg::FLAG_Z];
            c6502eu_pkg::K_BMI: take = flags_r[c6502eu_pkg::FLAG_N];
            c6502eu_pkg::K_BNE: take = !flags_r[c6502eu_pkg::FLAG_Z];
            c6502eu_pkg::K_BPL: take = !flags_r[c6502eu_pkg::FLAG_N];
            c6502eu_pkg::K_BVC: take = !flags_r[c6502eu_pkg::FLAG_V];
            c6502eu_pkg::K_BVS: take = flags_r[c6502eu_pkg::FLAG_V];
            c6502eu_pkg::K_JMP: pc_r = it.addr;
            c6502eu_pkg::K_TAX: begin x_r = acc_r; set_nz(x_r); end
            c6502eu_pkg::K_TAY: begin y_r = acc_r; set_nz(y_r); end
            c6502eu_pkg::K_TXA: begin acc_r = x_r; set_nz(acc_r); end
            c6502eu_pkg::K_TYA: begin acc_r = y_r; set_nz(acc_r); end
            c6502eu_pkg::K_TSX: begin x_r = sp_r; set_nz(x_r); end
            c6502eu_pkg::K_TXS: sp_r = x_r;
            default: ;
        endcase

        // Shifts and rotates share the write-back: even codes act on A, odd on memory.
        if (it.kind >= c6502eu_pkg::K_ASL_A && it.kind <= c6502eu_pkg::K_ROR_M) begin
            set_nz(t);
            if (!it.kind[0]) begin
                acc_r = t;
            end else begin
                wr    = 1'b1;
                wdata = t;
            end
        end

        if (take) begin
            pc_r = pc_r + {{8{it.offset[7]}}, it.offset};
            n_taken++;
        end
        if (wr) begin
            n_mem_writes++;
        end

        res.wr.valid = wr;
        res.wr.addr  = wr ? it.addr : 16'h0000;
        res.wr.data  = wr ? wdata : 8'h00;
        res.regs.a   = acc_r;
        res.regs.x   = x_r;
        res.regs.y   = y_r;
        res.regs.sp  = sp_r;
        res.regs.p   = flags_r;
        res.regs.pc  = pc_r;
        return res;
    endfunction

    function automatic int unsigned draw_wait(bit calm);
        if (calm || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
                $display("%0t: result %0d: %s is %h, expected %h",
                         $realtime, n_checked, name, got, want);
            end
        end
    endtask

    task automatic check_result();
        t_exec_result want;
        if (expected_state_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) begin
                $display("%0t: result word with nothing outstanding", $realtime);
            end
        end else begin
            want = expected_state_q.pop_front();
            compare_field("mem_write_valid", {15'd0, mem_wr_valid}, {15'd0, want.wr.valid});
            compare_field("mem_write_address", mem_wr_addr, want.wr.addr);
            compare_field("mem_write_data", {8'd0, mem_wr_data}, {8'd0, want.wr.data});
            compare_field("accumulator", {8'd0, acc_out}, {8'd0, want.regs.a});
            compare_field("index_x", {8'd0, x_out}, {8'd0, want.regs.x});
            compare_field("index_y", {8'd0, y_out}, {8'd0, want.regs.y});
            compare_field("stack_pointer", {8'd0, sp_out}, {8'd0, want.regs.sp});
            compare_field("status_flags", {8'd0, flags_out}, {8'd0, want.regs.p});
            compare_field("program_counter", pc_out, want.regs.pc);
        end
        n_checked++;
    endtask

    task automatic push_instr(logic [5:0] kind, logic [7:0] value, logic [15:0] addr,
                              logic [1:0] len, logic [7:0] offset, int unsigned gap,
                              bit drain);
        t_pending_instr p;
        p.instr.kind   = kind;
        p.instr.value  = value;
        p.instr.addr   = addr;
        p.instr.len    = len;
        p.instr.offset = offset;
        p.gap          = gap;
        p.drain        = drain;
        instr_q.push_back(p);
    endtask

    // Driver: an accepted word is run through the predictor at the edge that takes it.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            idle_cnt <= 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                expected_state_q.push_back(execute_instr(cur_instr));
                n_sent++;
            end
            if (instr_q.size() == 0 ||
                (instr_q[0].drain && expected_state_q.size() != 0)) begin
                in_valid <= 1'b0;
            end else if (idle_cnt < instr_q[0].gap) begin
                idle_cnt <= idle_cnt + 1;
                in_valid <= 1'b0;
            end else begin
                cur_instr <= instr_q[0].instr;
                void'(instr_q.pop_front());
                in_valid  <= 1'b1;
                idle_cnt  <= 0;
            end
        end
    end

    // Monitor: checks each result word and then stalls for a drawn number of cycles.
    always @(posedge clk) begin
        int unsigned n;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_cnt <= 0;
        end else if (out_valid && out_ready) begin
            check_result();
            n = draw_wait(((n_checked / 50) % 4) == 1);
            stall_cnt <= n;
            out_ready <= (n == 0);
        end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            out_ready <= (stall_cnt == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        #5000000;
        $display("cpu6502_execute_unit_top test failed");
        $finish;
    end

    initial begin
        logic [5:0]  kind;
        logic [7:0]  value;
        bit          calm;
        int unsigned k;

        // Directed: flag corner cases, signed branches, PC wrap and unused codes.
        push_instr(c6502eu_pkg::K_LDA, 8'h80, 16'h0000, 2'd1, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_ADC, 8'h80, 16'hFFFF, 2'd1, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_ADC, 8'h7F, 16'h0000, 2'd2, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_SBC, 8'h01, 16'h0000, 2'd1, 8'h00, 3, 1'b0);
        push_instr(c6502eu_pkg::K_CMP, 8'h7F, 16'h0000, 2'd1, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_BIT, 8'hC0, 16'h1234, 2'd2, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_BVS, 8'h00, 16'h0000, 2'd1, 8'h80, 0, 1'b0);
        push_instr(c6502eu_pkg::K_BMI, 8'h00, 16'h0000, 2'd1, 8'h7F, 1, 1'b0);
        push_instr(c6502eu_pkg::K_JMP, 8'hFF, 16'hFFFF, 2'd2, 8'hFF, 0, 1'b0);
        push_instr(c6502eu_pkg::K_LDX, 8'h00, 16'h0000, 2'd3, 8'h00, 0, 1'b0);
        push_instr(KIND_MAX, 8'hFF, 16'hFFFF, 2'd3, 8'hFF, 0, 1'b0);
        push_instr(c6502eu_pkg::K_TXS + 6'd1, 8'h55, 16'hAAAA, 2'd1, 8'h01, 0, 1'b0);
        push_instr(c6502eu_pkg::K_INC, 8'hFF, 16'hFFFF, 2'd2, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_DEC, 8'h00, 16'h8000, 2'd2, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_DEX, 8'h00, 16'h0000, 2'd0, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_TXS, 8'h00, 16'h0000, 2'd0, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_TSX, 8'h00, 16'h0000, 2'd0, 8'h00, 2, 1'b0);
        push_instr(c6502eu_pkg::K_ROR_A, 8'h00, 16'h0000, 2'd0, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_ROL_M, 8'h80, 16'h0000, 2'd1, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_LSR_M, 8'h01, 16'h00FF, 2'd1, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_ASL_M, 8'hFF, 16'hFF00, 2'd2, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_DEY, 8'h00, 16'h0000, 2'd0, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_BNE, 8'h00, 16'h0000, 2'd2, 8'hFF, 0, 1'b0);
        push_instr(c6502eu_pkg::K_CPX, 8'hFF, 16'h0000, 2'd1, 8'h00, 0, 1'b0);
        push_instr(c6502eu_pkg::K_BEQ, 8'h00, 16'h0000, 2'd1, 8'h10, 0, 1'b0);

        // Random: one pass over every operation, then mixed traffic with the odd unused code.
        for (int unsigned i = 0; i < RAND_INSTR; i++) begin
            calm = ((i / 60) % 4) == 2;
            if (i <= c6502eu_pkg::K_TXS) begin
                kind = i[5:0];
            end else begin
                kind = 6'($urandom_range(0, c6502eu_pkg::K_TXS));
            end
            value = 8'($urandom);
            k = $urandom_range(0, 9);
            if (k == 0) begin
                value = 8'h00;
            end else if (k == 1) begin
                value = 8'hFF;
            end else if (k == 2) begin
                value = 8'h80;
            end
            push_instr(kind, value, 16'($urandom), 2'($urandom_range(0, 3)), 8'($urandom),
                       draw_wait(calm), (i == 40 || i == RAND_INSTR / 2));
            if ($urandom_range(0, 19) == 0) begin
                push_instr(6'($urandom_range(c6502eu_pkg::K_TXS + 6'd1, KIND_MAX)),
                           8'($urandom), 16'($urandom), 2'($urandom_range(0, 3)),
                           8'($urandom), draw_wait(calm), 1'b0);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (instr_q.size() != 0 || in_valid || expected_state_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d instructions and checked %0d result words.", n_sent, n_checked);
        $display("Branches taken: %0d, memory writes: %0d, field errors: %0d.",
                 n_taken, n_mem_writes, n_errors);
        if (n_errors == 0 && expected_state_q.size() == 0) begin
            $display("cpu6502_execute_unit_top test passed");
        end else begin
            $display("cpu6502_execute_unit_top test failed");
        end
        $finish;
    end

endmodule

[sim.f]
sv/c6502eu_pkg.sv
sv/c6502eu_in_reg.sv
sv/c6502eu_alu.sv
sv/cpu6502_execute_unit_top.sv
sv/c6502eu_chk.sv
dv/cpu6502_execute_unit_top_tb.sv
